FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the page allocator
// ----------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, disabled while reset is asserted
`define ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/tppa_pkg.sv
// ----------------------------------------------------------------
// tppa_pkg
// types, sizes and codes shared by the page allocator modules
// ----------------------------------------------------------------
package tppa_pkg;

    // address and page geometry
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = 12;
    localparam int PNUM_W     = ADDR_W - PAGE_SHIFT;

    // free pool stacks
    localparam int POOL_DEPTH = 1024;
    localparam int POOL_AW    = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int POOL_CW    = $clog2(POOL_DEPTH + 1);

    // tracking table
    localparam int TRACK_DEPTH = 256;
    localparam int TRACK_AW    = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
    localparam int TRACK_CW    = $clog2(TRACK_DEPTH + 1);

    // register port
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_LOWEST_USABLE = 2'd0;
    localparam logic [1:0] REG_KERNEL_BASE   = 2'd1;
    localparam logic [1:0] REG_PHYS_TOP      = 2'd2;
    localparam logic [1:0] REG_LOCAL_BASE    = 2'd3;

    localparam logic [CFG_DW-1:0] RST_LOWEST_USABLE = 32'h0000_0000;
    localparam logic [CFG_DW-1:0] RST_KERNEL_BASE   = 32'h8000_0000;
    localparam logic [CFG_DW-1:0] RST_PHYS_TOP      = 32'h0E00_0000;
    localparam logic [CFG_DW-1:0] RST_LOCAL_BASE    = 32'h0000_0000;

    // request kinds in s_tuser[0]
    localparam logic REQ_FREE  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BADADDR = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    // tracking table scan kinds
    typedef enum logic {
        SCAN_EMPTY = 1'b0,
        SCAN_MATCH = 1'b1
    } scan_mode_t;

    typedef struct packed {
        logic [ADDR_W-1:0] lowest_usable_addr;
        logic [ADDR_W-1:0] kernel_base;
        logic [ADDR_W-1:0] phys_top;
        logic [ADDR_W-1:0] local_pool_base;
    } cfg_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       pop;
        logic       push;
        logic       capture;
        logic       st_load;
        status_t    st_code;
        logic       scan_start;
        scan_mode_t scan_mode;
        logic       scan_step;
        logic       out_load;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_alloc;
        logic sel_local;
        logic pool_empty;
        logic pool_full;
        logic addr_bad;
        logic scan_hit;
        logic scan_end;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/tppa_ram.sv
// ----------------------------------------------------------------
// tppa_ram
// generic simple dual port ram with registered read
// ----------------------------------------------------------------
module tppa_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                                          aclk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic                                          re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/tppa_regs.sv
// ----------------------------------------------------------------
// tppa_regs
// apb register file holding the address check settings
// ----------------------------------------------------------------
module tppa_regs
    import tppa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lowest_usable_addr <= RST_LOWEST_USABLE;
            cfg_reg.kernel_base        <= RST_KERNEL_BASE;
            cfg_reg.phys_top           <= RST_PHYS_TOP;
            cfg_reg.local_pool_base    <= RST_LOCAL_BASE;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_LOWEST_USABLE: cfg_reg.lowest_usable_addr <= pwdata;
                REG_KERNEL_BASE:   cfg_reg.kernel_base        <= pwdata;
                REG_PHYS_TOP:      cfg_reg.phys_top           <= pwdata;
                REG_LOCAL_BASE:    cfg_reg.local_pool_base    <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_LOWEST_USABLE: prdata = cfg_reg.lowest_usable_addr;
            REG_KERNEL_BASE:   prdata = cfg_reg.kernel_base;
            REG_PHYS_TOP:      prdata = cfg_reg.phys_top;
            REG_LOCAL_BASE:    prdata = cfg_reg.local_pool_base;
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/tppa_dp.sv
// ----------------------------------------------------------------
// tppa_dp
// datapath: request registers, pool stacks, tracking table scan
// and the result word register
// ----------------------------------------------------------------
module tppa_dp
    import tppa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  cmd_t              cmd,
    output sts_t              sts,
    input  logic [ADDR_W-1:0] s_tdata,
    input  logic [1:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ADDR_W-1:0] m_tdata,
    output logic [1:0]        m_tuser
);

    // request word
    logic              req_reg;
    logic              sel_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [PNUM_W-1:0] pn_reg;
    logic [ADDR_W-1:0] res_reg;
    status_t           st_reg;

    // pool counts
    logic [POOL_CW-1:0] gcnt_reg;
    logic [POOL_CW-1:0] lcnt_reg;
    logic [POOL_CW-1:0] gcnt_dec;
    logic [POOL_CW-1:0] lcnt_dec;

    // tracking table scan
    logic [TRACK_CW-1:0]    scan_idx_reg;
    logic [TRACK_AW-1:0]    cmp_idx_reg;
    logic                   cmp_pend_reg;
    scan_mode_t             mode_reg;
    logic [TRACK_DEPTH-1:0] track_valid_reg;
    logic [PNUM_W-1:0]      track_rdata;
    logic                   track_re;
    logic                   track_we;
    logic                   scan_more;
    logic                   hit;

    // output word
    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] m_tdata_reg;
    status_t           m_status_reg;

    // ram ports
    logic              g_we;
    logic              g_re;
    logic              l_we;
    logic              l_re;
    logic [PNUM_W-1:0] g_rdata;
    logic [PNUM_W-1:0] l_rdata;
    logic [PNUM_W-1:0] pop_data;

    // address checks
    logic [ADDR_W-1:0] phys;
    logic              free_local;

    assign phys       = addr_reg - cfg.kernel_base;
    assign free_local = (addr_reg >= cfg.local_pool_base);
    assign gcnt_dec   = gcnt_reg - POOL_CW'(1);
    assign lcnt_dec   = lcnt_reg - POOL_CW'(1);

    // status toward the controller
    always_comb begin
        sts.is_alloc   = (req_reg == REQ_ALLOC);
        sts.sel_local  = sel_reg;
        sts.pool_empty = sel_reg ? (lcnt_reg == '0) : (gcnt_reg == '0);
        sts.pool_full  = free_local ? (lcnt_reg == POOL_CW'(POOL_DEPTH))
                                    : (gcnt_reg == POOL_CW'(POOL_DEPTH));
        sts.addr_bad   = (addr_reg[PAGE_SHIFT-1:0] != '0)
                      || (addr_reg < cfg.lowest_usable_addr)
                      || (phys >= cfg.phys_top);
        sts.scan_hit   = hit;
        sts.scan_end   = cmp_pend_reg && !hit
                      && (cmp_idx_reg == TRACK_AW'(TRACK_DEPTH - 1));
        sts.out_free   = !m_tvalid_reg || m_tready;
    end

    // request registers
    assign pop_data = sel_reg ? l_rdata : g_rdata;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            req_reg  <= s_tuser[0];
            sel_reg  <= s_tuser[1];
            addr_reg <= s_tdata;
            pn_reg   <= s_tdata[ADDR_W-1:PAGE_SHIFT];
            res_reg  <= '0;
        end else if (cmd.capture) begin
            pn_reg  <= pop_data;
            res_reg <= {pop_data, {PAGE_SHIFT{1'b0}}};
        end
        if (cmd.st_load) begin
            st_reg <= cmd.st_code;
        end
    end

    // pool counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gcnt_reg <= '0;
            lcnt_reg <= '0;
        end else begin
            if (g_re) begin
                gcnt_reg <= gcnt_dec;
            end else if (g_we) begin
                gcnt_reg <= gcnt_reg + POOL_CW'(1);
            end
            if (l_re) begin
                lcnt_reg <= lcnt_dec;
            end else if (l_we) begin
                lcnt_reg <= lcnt_reg + POOL_CW'(1);
            end
        end
    end

    // pool stack rams
    assign g_we = cmd.push && !free_local;
    assign l_we = cmd.push && free_local;
    assign g_re = cmd.pop && !sel_reg;
    assign l_re = cmd.pop && sel_reg;

    tppa_ram #(
        .WIDTH (PNUM_W),
        .DEPTH (POOL_DEPTH)
    ) u_global_stack (
        .aclk  (aclk),
        .we    (g_we),
        .waddr (gcnt_reg[POOL_AW-1:0]),
        .wdata (pn_reg),
        .re    (g_re),
        .raddr (gcnt_dec[POOL_AW-1:0]),
        .rdata (g_rdata)
    );

    tppa_ram #(
        .WIDTH (PNUM_W),
        .DEPTH (POOL_DEPTH)
    ) u_local_stack (
        .aclk  (aclk),
        .we    (l_we),
        .waddr (lcnt_reg[POOL_AW-1:0]),
        .wdata (pn_reg),
        .re    (l_re),
        .raddr (lcnt_dec[POOL_AW-1:0]),
        .rdata (l_rdata)
    );

    // tracking table compare stage, page zero is never stored as valid
    always_comb begin
        if (!cmp_pend_reg) begin
            hit = 1'b0;
        end else if (mode_reg == SCAN_EMPTY) begin
            hit = !track_valid_reg[cmp_idx_reg];
        end else begin
            hit = track_valid_reg[cmp_idx_reg] && (track_rdata == pn_reg);
        end
    end

    assign scan_more = (scan_idx_reg != TRACK_CW'(TRACK_DEPTH));
    assign track_re  = cmd.scan_step && scan_more;
    assign track_we  = cmd.scan_step && hit && (mode_reg == SCAN_EMPTY)
                    && (pn_reg != '0);

    // scan pointer, one entry read per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmp_pend_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            cmp_pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            cmp_pend_reg <= scan_more && !hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_start) begin
            scan_idx_reg <= '0;
            mode_reg     <= cmd.scan_mode;
        end else if (track_re) begin
            scan_idx_reg <= scan_idx_reg + TRACK_CW'(1);
            cmp_idx_reg  <= scan_idx_reg[TRACK_AW-1:0];
        end
    end

    // entry valid bits, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_valid_reg <= '0;
        end else if (cmd.scan_step && hit) begin
            if (mode_reg == SCAN_EMPTY) begin
                track_valid_reg[cmp_idx_reg] <= (pn_reg != '0);
            end else begin
                track_valid_reg[cmp_idx_reg] <= 1'b0;
            end
        end
    end

    tppa_ram #(
        .WIDTH (PNUM_W),
        .DEPTH (TRACK_DEPTH)
    ) u_track_table (
        .aclk  (aclk),
        .we    (track_we),
        .waddr (cmp_idx_reg),
        .wdata (pn_reg),
        .re    (track_re),
        .raddr (scan_idx_reg[TRACK_AW-1:0]),
        .rdata (track_rdata)
    );

    // result word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg  <= res_reg;
            m_status_reg <= st_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

endmodule

FILE: hdl/tppa_ctrl.sv
// ----------------------------------------------------------------
// tppa_ctrl
// request sequencer: checks, stack access, table scan, result hand-off
// ----------------------------------------------------------------
module tppa_ctrl
    import tppa_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        IDLE,
        EVAL,
        POPWAIT,
        SCAN,
        FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.st_code    = ST_OK;
        cmd.scan_mode  = SCAN_EMPTY;
        s_tready       = 1'b0;
        unique case (state_reg)
            IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = EVAL;
                end
            end
            EVAL: begin
                cmd.st_load = 1'b1;
                if (sts.is_alloc) begin
                    if (sts.pool_empty) begin
                        cmd.st_code = ST_EMPTY;
                        state_next  = FINISH;
                    end else begin
                        cmd.pop    = 1'b1;
                        state_next = POPWAIT;
                    end
                end else if (sts.addr_bad) begin
                    cmd.st_code = ST_BADADDR;
                    state_next  = FINISH;
                end else if (sts.pool_full) begin
                    cmd.st_code = ST_FULL;
                    state_next  = FINISH;
                end else begin
                    // page pushed, then drop its table entry
                    cmd.push       = 1'b1;
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_MATCH;
                    state_next     = SCAN;
                end
            end
            POPWAIT: begin
                cmd.capture = 1'b1;
                if (sts.sel_local) begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_EMPTY;
                    state_next     = SCAN;
                end else begin
                    state_next = FINISH;
                end
            end
            SCAN: begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_end) begin
                    state_next = FINISH;
                end
            end
            FINISH: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/two_pool_page_allocator.sv
// ----------------------------------------------------------------
// two_pool_page_allocator
// 4 KiB page allocator with a global and a local lifo free pool
// and a tracking table of pages handed out from the local pool
// ----------------------------------------------------------------
//  channel   direction  contents
//  s_        in         tdata page_addr, tuser req_type / pool_select
//  m_        out        tdata result_addr, tuser status
//  apb       in/out     four 32 bit settings at byte offsets 0..12
//
//  one word is worked on at a time; a finished word waits in the
//  output register while the next request is taken
//  errors, empty pools and global allocates need no table scan
//  frees and local allocates add a scan of the tracking table ram,
//  one entry a cycle, ending at a hit or at the last entry
//  reset clears counts and table valid bits at once, no clearing pass
`include "assert_macros.svh"

module two_pool_page_allocator
    import tppa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // slave side
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ADDR_W-1:0] s_tdata,  // [31:0] page_addr
    input  logic [1:0]        s_tuser,  // [0] req_type, [1] pool_select
    // master side
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [ADDR_W-1:0] m_tdata,  // [31:0] result_addr
    output logic [1:0]        m_tuser,  // [1:0] status
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [CFG_DW-1:0] pwdata,
    output logic [CFG_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    tppa_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    tppa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    tppa_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .sts      (sts),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // checks on the sequencer and datapath
    `ASSERT_RST(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "request taken while busy")
    `ASSERT_ALWAYS(a_out_no_overwrite, aclk, cmd.out_load |-> (!m_tvalid || m_tready), "result word overwritten")
    `ASSERT_ALWAYS(a_pop_not_empty, aclk, cmd.pop |-> !sts.pool_empty, "pop from empty pool")
    `ASSERT_ALWAYS(a_push_not_full, aclk, cmd.push |-> (!sts.pool_full && !sts.addr_bad), "bad push")

endmodule
